// ===== sv/assert_macros.svh =====
// Assertion macros shared by the wave stencil update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define WSU_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define WSU_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== sv/wsu_pkg.sv =====
// Shared types and constants of the wave stencil update core.
`default_nettype none

package wsu_pkg;

    localparam int MAX_POINTS_DEF = 128;
    localparam int GRID_MIN       = 3;
    localparam int GRID_RESET     = 128;
    localparam int GRID_SIZE_W    = 8;

    localparam int WORD_W = 32;
    localparam int PEB_W  = 4;

    localparam logic [31:0] LAP_GAIN_RESET   = 32'd107374182;
    localparam logic [31:0] FORCE_GAIN_RESET = 32'd6554;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE  = 2'd0,
        CFG_LAP_GAIN   = 2'd1,
        CFG_FORCE_GAIN = 2'd2
    } t_cfg_idx;

    // One grid point going in
    typedef struct packed {
        logic signed [WORD_W-1:0] cur_value;
        logic signed [WORD_W-1:0] old_value;
        logic [PEB_W-1:0]         pebble_size;
    } t_in_item;

    // One updated point coming out
    typedef struct packed {
        logic signed [WORD_W-1:0] new_value;
        logic                     frame_last;
    } t_out_item;

    // Taps of one row cell: delayed by its length, and by one more
    typedef struct packed {
        logic signed [WORD_W-1:0] near;
        logic signed [WORD_W-1:0] far;
    } t_cell_tap;

endpackage

`default_nettype wire

// ===== sv/wsu_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module wsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 127
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a same-address access
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/wsu_row_cell.sv =====
// Row cell: a programmable delay line of one grid row, with two output taps.
`default_nettype none
`include "assert_macros.svh"

module wsu_row_cell #(
    parameter int MAX_POINTS = wsu_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_shift,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_len,
    input  logic signed [wsu_pkg::WORD_W-1:0] i_word,
    output wsu_pkg::t_cell_tap                o_tap
);

    localparam int Depth = MAX_POINTS - 1;
    localparam int LW    = $clog2(MAX_POINTS);
    localparam int AW    = $clog2(Depth);

    logic [AW-1:0]                     r_ptr;
    logic [AW-1:0]                     n_ptr;
    logic [wsu_pkg::WORD_W-1:0]        ram_rdata;
    logic signed [wsu_pkg::WORD_W-1:0] r_far;

    // Advance the circular pointer, wrap at the row length
    always_comb begin
        if (LW'(r_ptr) >= i_len - LW'(1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_shift) begin
            r_ptr <= n_ptr;
        end
    end

    // Word stored one row ago comes back as the new word goes in
    wsu_ram #(
        .WIDTH (wsu_pkg::WORD_W),
        .DEPTH (Depth)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (r_ptr),
        .i_wdata (i_word),
        .i_re    (i_shift),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // Hold the next older word for the neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_far <= ram_rdata;
        end
    end

    assign o_tap.near = ram_rdata;
    assign o_tap.far  = r_far;

    `WSU_ASSERT_NEXT(a_ptr_in_row, i_clk, i_rst_n,
        i_shift && (LW'(r_ptr) < i_len), LW'(r_ptr) < $past(i_len),
        "row cell pointer left the row")

endmodule

`default_nettype wire

// ===== sv/wave_stencil_update_core.sv =====
// Top level of the wave stencil update core.
// One time step of the 2D wave equation over an n by n grid (n set by grid_size, held
// to 3..MAX_POINTS). Feed the grid in raster order followed by n padding items; each
// item after the first row yields the result for the point one row back, so a frame of
// n*n + n items gives n*n results, the last flagged by frame_last. Border points give
// zero; interior points give 2c - old + laplacian_gain*(sum of neighbors - 4c) -
// forcing_gain*pebble_size, rounded half up to Q16.16 and saturated. The block takes
// one item per clock cycle and keeps that rate under output stalls until its five
// stages fill; a result moves through the registered stages A, B, C, D and E in order.
// Two chained row cells,
// each a RAM delay line of n-1 words with a registered read, hold the two rows of the
// stencil window. Write configuration only between frames with no results pending;
// the line RAMs are not cleared, and the first rows of a frame are never read before
// they are written.
`default_nettype none
`include "assert_macros.svh"

module wave_stencil_update_core #(
    parameter int MAX_POINTS = wsu_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  wsu_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output wsu_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [wsu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wsu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int LW     = $clog2(MAX_POINTS);
    localparam int CW     = LW;
    localparam int CmpW   = (NW > wsu_pkg::GRID_SIZE_W) ? NW : wsu_pkg::GRID_SIZE_W;
    localparam int NReset = (wsu_pkg::GRID_RESET > MAX_POINTS) ? MAX_POINTS
                                                               : wsu_pkg::GRID_RESET;

    localparam int WW     = wsu_pkg::WORD_W;
    localparam int FracW  = 16;
    localparam int SumW   = WW + 3;
    localparam int ForceW = WW + wsu_pkg::PEB_W;
    localparam int HalfW  = FracW + 1;
    localparam int ProdW  = SumW + FracW;
    localparam int AccW   = SumW + WW + 1;
    localparam int TermW  = AccW - WW;
    localparam int ResW   = TermW + 1;

    localparam logic signed [AccW-1:0] LapRound   = AccW'({1'b1, {(WW-1){1'b0}}});
    localparam logic [ForceW-1:0]      ForceRound = ForceW'({1'b1, {(FracW-1){1'b0}}});
    localparam logic signed [WW-1:0]   SatMax     = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0]   SatMin     = {1'b1, {(WW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NW-1:0]   r_grid_n;
    logic [NW-1:0]   n_grid_n;
    logic [CmpW-1:0] cfg_grid;
    logic [WW-1:0]   r_lap_gain;
    logic [WW-1:0]   r_force_gain;

    // Clamp the written grid size to the supported range
    always_comb begin
        cfg_grid = CmpW'(i_cfg_wdata[wsu_pkg::GRID_SIZE_W-1:0]);
        if (cfg_grid < CmpW'(wsu_pkg::GRID_MIN)) begin
            n_grid_n = NW'(wsu_pkg::GRID_MIN);
        end else if (cfg_grid > CmpW'(MAX_POINTS)) begin
            n_grid_n = NW'(MAX_POINTS);
        end else begin
            n_grid_n = NW'(cfg_grid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n     <= NW'(NReset);
            r_lap_gain   <= wsu_pkg::LAP_GAIN_RESET;
            r_force_gain <= wsu_pkg::FORCE_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (wsu_pkg::t_cfg_idx'(i_cfg_idx))
                wsu_pkg::CFG_GRID_SIZE:  r_grid_n     <= n_grid_n;
                wsu_pkg::CFG_LAP_GAIN:   r_lap_gain   <= i_cfg_wdata;
                wsu_pkg::CFG_FORCE_GAIN: r_force_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic free_a, free_b, free_c, free_d, free_e;
    logic accept;

    assign free_e     = !r_e_valid || i_out_ready;
    assign free_d     = !r_d_valid || free_e;
    assign free_c     = !r_c_valid || free_d;
    assign free_b     = !r_b_valid || free_c;
    assign free_a     = !r_a_valid || free_b;
    assign o_in_ready = free_a;
    assign accept     = i_in_valid && free_a;

    // ------------------------------------------------------------------
    // Raster position of the incoming point
    // ------------------------------------------------------------------
    logic [NW-1:0] r_row;
    logic [NW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          row_end;

    always_comb begin
        row_end = NW'(r_col) >= (r_grid_n - NW'(1));
        if (row_end) begin
            n_col = '0;
            n_row = (r_row >= r_grid_n) ? '0 : r_row + NW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Classify the centre point one row back
    logic              produce;
    logic              interior;
    logic              last_point;
    logic signed [WW-1:0] push_word;

    always_comb begin
        push_word  = (r_row < r_grid_n) ? i_in_item.cur_value : '0;
        produce    = (r_row != '0) && (r_row <= r_grid_n);
        interior   = (r_row >= NW'(2)) && (r_row < r_grid_n) && (r_col != '0)
                     && (NW'(r_col) < r_grid_n - NW'(1));
        last_point = (r_row == r_grid_n) && (NW'(r_col) == r_grid_n - NW'(1));
    end

    // ------------------------------------------------------------------
    // Stencil window: newest word, two chained row cells, one tap between
    // ------------------------------------------------------------------
    wsu_pkg::t_cell_tap       tap0;
    wsu_pkg::t_cell_tap       tap1;
    logic [LW-1:0]            row_len;
    logic signed [WW-1:0]     r_down;
    logic signed [WW-1:0]     r_left;

    assign row_len = LW'(r_grid_n - NW'(1));

    wsu_row_cell #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cell_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept),
        .i_len   (row_len),
        .i_word  (push_word),
        .o_tap   (tap0)
    );

    wsu_row_cell #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cell_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (accept),
        .i_len   (row_len),
        .i_word  (tap0.far),
        .o_tap   (tap1)
    );

    // Stage A: window taps and the centre's side data
    logic                           r_a_interior;
    logic                           r_a_last;
    logic signed [WW-1:0]           r_a_old;
    logic [wsu_pkg::PEB_W-1:0]      r_a_peb;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_down       <= push_word;
            r_left       <= tap0.far;
            r_a_interior <= interior;
            r_a_last     <= last_point;
            r_a_old      <= i_in_item.old_value;
            r_a_peb      <= i_in_item.pebble_size;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: neighbor sum and the non-Laplacian part
    // ------------------------------------------------------------------
    logic signed [SumW-1:0] n_b_lap;
    logic signed [SumW-1:0] n_b_base;
    logic [ForceW-1:0]      force_prod;
    logic signed [SumW-1:0] r_b_lap;
    logic signed [SumW-1:0] r_b_base;
    logic                   r_b_interior;
    logic                   r_b_last;

    always_comb begin
        n_b_lap    = SumW'(r_left) + SumW'(tap0.near) + SumW'(r_down) + SumW'(tap1.near)
                     - (SumW'(tap0.far) <<< 2);
        force_prod = ForceW'(r_force_gain) * ForceW'(r_a_peb) + ForceRound;
        n_b_base   = (SumW'(tap0.far) <<< 1) - SumW'(r_a_old)
                     - SumW'(force_prod[ForceW-1:FracW]);
    end

    always_ff @(posedge i_clk) begin
        if (free_b) begin
            r_b_lap      <= n_b_lap;
            r_b_base     <= n_b_base;
            r_b_interior <= r_a_interior;
            r_b_last     <= r_a_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: scale by the gain in two half-word products
    // ------------------------------------------------------------------
    logic signed [HalfW-1:0] gain_hi;
    logic signed [HalfW-1:0] gain_lo;
    logic signed [ProdW-1:0] r_c_phi;
    logic signed [ProdW-1:0] r_c_plo;
    logic signed [SumW-1:0]  r_c_base;
    logic                    r_c_interior;
    logic                    r_c_last;

    assign gain_hi = {1'b0, r_lap_gain[WW-1:FracW]};
    assign gain_lo = {1'b0, r_lap_gain[FracW-1:0]};

    always_ff @(posedge i_clk) begin
        if (free_c) begin
            r_c_phi      <= ProdW'(r_b_lap) * ProdW'(gain_hi);
            r_c_plo      <= ProdW'(r_b_lap) * ProdW'(gain_lo);
            r_c_base     <= r_b_base;
            r_c_interior <= r_b_interior;
            r_c_last     <= r_b_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: join the products, round half up to Q16.16
    // ------------------------------------------------------------------
    logic signed [AccW-1:0]  lap_acc;
    logic signed [TermW-1:0] r_d_term;
    logic signed [SumW-1:0]  r_d_base;
    logic                    r_d_interior;
    logic                    r_d_last;

    assign lap_acc = (AccW'(r_c_phi) <<< FracW) + AccW'(r_c_plo) + LapRound;

    always_ff @(posedge i_clk) begin
        if (free_d) begin
            r_d_term     <= lap_acc[AccW-1:WW];
            r_d_base     <= r_c_base;
            r_d_interior <= r_c_interior;
            r_d_last     <= r_c_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: final sum, saturate, zero the border, output register
    // ------------------------------------------------------------------
    logic signed [ResW-1:0] res_sum;
    logic signed [WW-1:0]   res_sat;
    wsu_pkg::t_out_item     r_out;

    always_comb begin
        res_sum = ResW'(r_d_base) + ResW'(r_d_term);
        if ((&res_sum[ResW-1:WW-1]) || !(|res_sum[ResW-1:WW-1])) begin
            res_sat = res_sum[WW-1:0];
        end else if (res_sum[ResW-1]) begin
            res_sat = SatMin;
        end else begin
            res_sat = SatMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_e) begin
            r_out.new_value  <= r_d_interior ? res_sat : '0;
            r_out.frame_last <= r_d_last;
        end
    end

    // Advance the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (free_a) begin
                r_a_valid <= accept && produce;
            end
            if (free_b) begin
                r_b_valid <= r_a_valid;
            end
            if (free_c) begin
                r_c_valid <= r_b_valid;
            end
            if (free_d) begin
                r_d_valid <= r_c_valid;
            end
            if (free_e) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    assign o_out_valid = r_e_valid;
    assign o_out_item  = r_out;

    `WSU_ASSERT_SAME(a_full_blocks_input, i_clk, i_rst_n,
        r_a_valid && r_b_valid && r_c_valid && r_d_valid && r_e_valid && !i_out_ready,
        !o_in_ready, "input taken while every stage is stalled")

    `WSU_ASSERT_SAME(a_empty_takes_input, i_clk, i_rst_n,
        !r_a_valid, o_in_ready, "input refused with the window stage empty")

    `WSU_ASSERT_SAME(a_last_is_border, i_clk, i_rst_n,
        o_out_valid && o_out_item.frame_last, o_out_item.new_value == '0,
        "last grid point of a frame carries a nonzero value")

    `WSU_ASSERT_NEXT(a_window_follows_accept, i_clk, i_rst_n,
        accept && produce, r_a_valid, "centre point lost after its transaction")

endmodule

`default_nettype wire

// ===== verif/wave_stencil_update_core_tb.sv =====
// Self-checking testbench for the wave stencil update core: streamed frames against a predictor.
`timescale 1ns / 100ps

module wave_stencil_update_core_tb;

    localparam int WIN_LEN      = 2 * wsu_pkg::MAX_POINTS_DEF + 1;
    localparam int IDLE_PCT     = 22;
    localparam int SLACK_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_ROWS    = 3;
    localparam int TAIL_EXTRA   = 8;

    localparam logic signed [31:0] H_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] H_MIN = 32'sh8000_0000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    wsu_pkg::t_in_item              i_in_item   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    wsu_pkg::t_out_item             o_out_item;
    logic                           i_cfg_we    = 1'b0;
    logic [wsu_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [wsu_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Points waiting for the driver, and updated heights waiting for the block
    wsu_pkg::t_in_item  stim_points[$];
    wsu_pkg::t_out_item expected_heights[$];

    // Predictor state: register copies, line history and raster position
    logic [7:0]         grid_reg       = 8'(wsu_pkg::GRID_RESET);
    logic [31:0]        lap_gain_reg   = wsu_pkg::LAP_GAIN_RESET;
    logic [31:0]        force_gain_reg = wsu_pkg::FORCE_GAIN_RESET;
    logic signed [31:0] win_hist[WIN_LEN];
    int                 pos_row        = 0;
    int                 pos_col        = 0;

    // Traffic shaping
    logic steady    = 1'b0;
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    wave_stencil_update_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Grid size in use, held to the supported range
    function automatic int active_size();
        if (grid_reg < wsu_pkg::GRID_MIN) return wsu_pkg::GRID_MIN;
        if (grid_reg > wsu_pkg::MAX_POINTS_DEF) return wsu_pkg::MAX_POINTS_DEF;
        return int'(grid_reg);
    endfunction

    // Height mix: extremes, zero, small values and full-range noise
    function automatic logic signed [31:0] pick_height();
        unique case ($urandom_range(0, 7))
            0: return H_MAX;
            1: return H_MIN;
            2: return '0;
            3, 4: return 32'($urandom_range(0, 524288)) - 32'd262144;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        unique case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h1000_0000);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t %s: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Push one point through the line history and predict the centre update
    task automatic advance_stencil(input wsu_pkg::t_in_item pt);
        int                 n;
        int                 ci;
        int                 cj;
        longint             c;
        longint             up;
        longint             dn;
        longint             lf;
        longint             rt;
        longint             lap;
        longint             lap_term;
        longint             force_term;
        longint             acc;
        logic signed [95:0] lap_w;
        logic signed [95:0] gain_w;
        logic signed [95:0] rnd_w;
        wsu_pkg::t_out_item res;
        n = active_size();
        for (int k = WIN_LEN - 1; k > 0; k--) win_hist[k] = win_hist[k-1];
        win_hist[0] = (pos_row < n) ? pt.cur_value : '0;

        if (pos_row >= 1 && pos_row - 1 < n) begin
            ci  = pos_row - 1;
            cj  = pos_col;
            acc = 0;
            if (ci != 0 && ci < n - 1 && cj != 0 && cj < n - 1) begin
                c   = win_hist[n];
                dn  = win_hist[0];
                rt  = win_hist[n-1];
                lf  = win_hist[n+1];
                up  = win_hist[2*n];
                lap = up + dn + lf + rt - 4 * c;
                // Exact product, round half up to Q16.16
                lap_w    = lap;
                gain_w   = {64'd0, lap_gain_reg};
                rnd_w    = (lap_w * gain_w + (96'sd1 <<< 31)) >>> 32;
                lap_term = rnd_w[63:0];
                force_term = (longint'(force_gain_reg) * longint'(pt.pebble_size)
                              + 64'sd32768) >>> 16;
                acc = 2 * c - longint'(pt.old_value) + lap_term - force_term;
                if (acc > longint'(H_MAX)) acc = longint'(H_MAX);
                if (acc < longint'(H_MIN)) acc = longint'(H_MIN);
            end
            res.new_value  = acc[31:0];
            res.frame_last = (ci == n - 1 && cj == n - 1);
            expected_heights.push_back(res);
        end

        // Advance raster position; padding row wraps to a new frame
        if (pos_col >= n - 1) begin
            pos_col = 0;
            pos_row = (pos_row >= n) ? 0 : pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endtask

    task automatic write_reg(input wsu_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            wsu_pkg::CFG_GRID_SIZE:  grid_reg       = val[7:0];
            wsu_pkg::CFG_LAP_GAIN:   lap_gain_reg   = val;
            wsu_pkg::CFG_FORCE_GAIN: force_gain_reg = val;
            default: ;
        endcase
    endtask

    // Wait for every queued point and every predicted height, then let the pipe empty
    task automatic settle_idle();
        @(negedge i_clk);
        while (stim_points.size() != 0 || i_in_valid || expected_heights.size() != 0)
            @(negedge i_clk);
        repeat (SLACK_CYCLES) @(posedge i_clk);
    endtask

    // Queue a number of random points
    task automatic queue_points(input int count);
        wsu_pkg::t_in_item pt;
        for (int k = 0; k < count; k++) begin
            pt.cur_value   = pick_height();
            pt.old_value   = pick_height();
            pt.pebble_size = $urandom_range(0, 9);
            stim_points.push_back(pt);
        end
    endtask

    // Queue one full frame of random points plus its padding row
    task automatic queue_frame();
        int n;
        n = active_size();
        queue_points(n * n + n);
    endtask

    // Driver: present the next point once the current transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (stim_points.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_item  <= stim_points.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off once results flow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_go && !hold_done && o_out_valid) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check each result transaction, predict on each input transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if (expected_heights.size() == 0) begin
                    report_mismatch("unexpected result", o_out_item.new_value, 'x);
                end else begin
                    if (o_out_item.new_value !== expected_heights[0].new_value)
                        report_mismatch("new_value", o_out_item.new_value,
                                        expected_heights[0].new_value);
                    if (o_out_item.frame_last !== expected_heights[0].frame_last)
                        report_mismatch("frame_last", 32'(o_out_item.frame_last),
                                        32'(expected_heights[0].frame_last));
                    void'(expected_heights.pop_front());
                end
            end
            if (in_fire) advance_stencil(i_in_item);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || out_fire) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("wave_stencil_update_core test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int                random_items;
        int                phase;
        int                frames;
        int                n;
        int                row;
        int                col;
        wsu_pkg::t_in_item pt;
        random_items = 0;
        phase        = 0;
        for (int k = 0; k < WIN_LEN; k++) win_hist[k] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3 frame, grid size below range, gains at full scale,
        // centre at max against min neighbors drives the sum to negative saturation
        write_reg(wsu_pkg::CFG_GRID_SIZE, 32'd0);
        write_reg(wsu_pkg::CFG_LAP_GAIN, 32'hFFFF_FFFF);
        write_reg(wsu_pkg::CFG_FORCE_GAIN, 32'hFFFF_FFFF);
        for (int k = 0; k < 12; k++) begin
            row = k / 3;
            col = k % 3;
            pt.cur_value   = ((row + col) % 2 == 0) ? H_MAX : H_MIN;
            pt.old_value   = H_MAX;
            pt.pebble_size = 4'd9;
            stim_points.push_back(pt);
        end
        settle_idle();

        // Directed: zero gains, old at min, positive saturation
        write_reg(wsu_pkg::CFG_GRID_SIZE, 32'd2);
        write_reg(wsu_pkg::CFG_LAP_GAIN, 32'd0);
        write_reg(wsu_pkg::CFG_FORCE_GAIN, 32'd0);
        for (int k = 0; k < 12; k++) begin
            row = k / 3;
            col = k % 3;
            pt.cur_value   = ((row + col) % 2 == 0) ? H_MAX : H_MIN;
            pt.old_value   = H_MIN;
            pt.pebble_size = (k % 2) ? 4'd9 : 4'd0;
            stim_points.push_back(pt);
        end
        settle_idle();

        // Mid-size grid with a long output hold-off so the pipe backs up
        write_reg(wsu_pkg::CFG_GRID_SIZE, 32'd16);
        write_reg(wsu_pkg::CFG_LAP_GAIN, wsu_pkg::LAP_GAIN_RESET);
        write_reg(wsu_pkg::CFG_FORCE_GAIN, wsu_pkg::FORCE_GAIN_RESET);
        hold_go = 1'b1;
        queue_frame();
        settle_idle();

        // Random phases: new settings, then a few whole frames
        while (random_items < RANDOM_ITEMS) begin
            unique case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 2);
                1: n = $urandom_range(11, 16);
                default: n = $urandom_range(3, 10);
            endcase
            write_reg(wsu_pkg::CFG_GRID_SIZE, 32'(n));
            write_reg(wsu_pkg::CFG_LAP_GAIN, pick_gain());
            write_reg(wsu_pkg::CFG_FORCE_GAIN, pick_gain());
            steady = (phase == 2);
            frames = $urandom_range(1, 3);
            n = active_size();
            for (int f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
                queue_frame();
                random_items += n * n + n;
            end
            settle_idle();
            phase++;
        end
        steady = 1'b0;

        // Grid size above range, no idling: the first rows of the largest grid,
        // enough for interior points that reach back two full rows
        write_reg(wsu_pkg::CFG_GRID_SIZE, 32'd255);
        write_reg(wsu_pkg::CFG_LAP_GAIN, pick_gain());
        write_reg(wsu_pkg::CFG_FORCE_GAIN, pick_gain());
        steady = 1'b1;
        n = active_size();
        queue_points(TAIL_ROWS * n + TAIL_EXTRA);
        settle_idle();
        steady = 1'b0;

        if (mismatch_count == 0)
            $display("wave_stencil_update_core test passed");
        else
            $display("wave_stencil_update_core test failed");
        $finish;
    end

endmodule
